// ===== design/pgi_pkg.sv =====
// ----------------------------------------------------------------------------
// pgi_pkg
// Shared types and constants of the palette gradient interpolator.
// ----------------------------------------------------------------------------
package pgi_pkg;

  localparam int GRAY_W    = 16;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 4 * CHAN_W;
  localparam int STOP_W    = GRAY_W + COLOR_W;
  localparam int COUNT_W   = 4;
  localparam int INDEX_W   = 3;
  localparam int WEIGHT_W  = GRAY_W + 1;
  localparam int DIV_STEPS = WEIGHT_W;
  localparam int CHANNELS  = 4;
  localparam int STEP_W    = 5;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [COUNT_W-1:0] STOP_COUNT_RESET = COUNT_W'(2);

  // controller to datapath
  typedef struct packed {
    logic wr;         // store the stop on the input
    logic start;      // latch gray value, clear result, restart scan
    logic scan;       // read and compare stops
    logic div_step;   // one quotient bit of the lower weight
    logic div_first;  // first quotient bit, no shift of remainder
    logic blend_step; // blend one channel
    logic take_lo;    // equal bounds: result is the lower stop colour
    logic load_out;   // move result into output register
  } pgi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_lookup;  // input beat is a lookup
    logic few;        // fewer than two stops in use
    logic hit;        // scan found a segment
    logic equal;      // found segment has equal bounds
    logic miss;       // scan ran out of segments
  } pgi_status_t;

endpackage

// ===== design/pgi_if.sv =====
// ----------------------------------------------------------------------------
// pgi_in_if / pgi_out_if
// Valid/ready channels of the palette gradient interpolator.
// ----------------------------------------------------------------------------
interface pgi_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  stop_index;
  logic [15:0] stop_gray;
  logic [7:0]  stop_red;
  logic [7:0]  stop_green;
  logic [7:0]  stop_blue;
  logic [7:0]  stop_alpha;
  logic [15:0] gray_value;

  modport source (
    output valid, command, stop_index, stop_gray, stop_red, stop_green,
           stop_blue, stop_alpha, gray_value,
    input  ready
  );
  modport sink (
    input  valid, command, stop_index, stop_gray, stop_red, stop_green,
           stop_blue, stop_alpha, gray_value,
    output ready
  );
endinterface

interface pgi_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] segment;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (
    output valid, found, segment, red, green, blue, alpha,
    input  ready
  );
  modport sink (
    input  valid, found, segment, red, green, blue, alpha,
    output ready
  );
endinterface

// ===== design/pgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// pgi_ctrl
// Sequencer of the interpolator: scan, divide, blend, hand over the result.
// ----------------------------------------------------------------------------
module pgi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pgi_pkg::pgi_status_t  status_i,
  output pgi_pkg::pgi_cmd_t     cmd_o
);
  import pgi_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_BLEND = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] BLEND_LAST = STEP_W'(CHANNELS - 1);

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;
  logic              out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (status_i.in_lookup) begin
            cmd_o.start = 1'b1;
            state_d     = status_i.few ? ST_DONE : ST_SCAN;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          cnt_d = '0;
          if (status_i.equal) begin
            cmd_o.take_lo = 1'b1;
            state_d       = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end else if (status_i.miss) begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = ST_BLEND;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_BLEND: begin
        cmd_o.blend_step = 1'b1;
        if (cnt_q == BLEND_LAST) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/pgi_datapath.sv =====
// ----------------------------------------------------------------------------
// pgi_datapath
// Stop memory, segment scan, restoring divider, channel blender, result regs.
// ----------------------------------------------------------------------------
module pgi_datapath #(
  parameter int MAX_STOPS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pgi_pkg::pgi_cmd_t                cmd_i,
  output pgi_pkg::pgi_status_t             status_o,
  input  logic                             cfg_we_i,
  input  logic [pgi_pkg::COUNT_W-1:0]      cfg_data_i,
  input  logic                             command_i,
  input  logic [pgi_pkg::INDEX_W-1:0]      stop_index_i,
  input  logic [pgi_pkg::GRAY_W-1:0]       stop_gray_i,
  input  logic [pgi_pkg::COLOR_W-1:0]      stop_color_i,
  input  logic [pgi_pkg::GRAY_W-1:0]       gray_value_i,
  output logic                             found_o,
  output logic [pgi_pkg::INDEX_W-1:0]      segment_o,
  output logic [pgi_pkg::COLOR_W-1:0]      color_o
);
  import pgi_pkg::*;

  localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CW = $clog2(MAX_STOPS + 1);

  // stop memory: gray in the top bits, colour below
  logic [STOP_W-1:0] stop_mem_q [MAX_STOPS];
  logic [STOP_W-1:0] rdata_q;

  logic [COUNT_W-1:0]  stop_count_q;
  logic [7:0]          count_ext, n_ext, widx_ext;
  logic [AW-1:0]       waddr;
  logic                wr_ok;

  logic [GRAY_W-1:0]   value_q;
  logic [CW-1:0]       n_q, ptr_q, arr_idx;
  logic                dv_q, have_lo_q, rd_en;
  logic [GRAY_W-1:0]   lo_gray_q, rd_gray;
  logic [COLOR_W-1:0]  lo_col_q, hi_col_q, rd_col;
  logic [AW-1:0]       lo_idx_q;
  logic                hit;

  logic [WEIGHT_W-1:0] rem_q, q_q, div_t, div_d, w2;
  logic [GRAY_W-1:0]   dsr_q;
  logic                div_ge;
  logic [24:0]         acc;

  logic                res_found_q, found_q;
  logic [AW-1:0]       res_seg_q;
  logic [COLOR_W-1:0]  res_col_q, color_q;
  logic [INDEX_W-1:0]  segment_q;
  logic [7:0]          seg_ext;

  // write path
  assign widx_ext = 8'(stop_index_i);
  assign wr_ok    = widx_ext < 8'(MAX_STOPS);
  assign waddr    = widx_ext[AW-1:0];

  // stop count saturates to the store depth
  assign count_ext = 8'(stop_count_q);
  assign n_ext     = (count_ext > 8'(MAX_STOPS)) ? 8'(MAX_STOPS) : count_ext;

  assign rd_en   = cmd_i.scan && (ptr_q < n_q);
  assign arr_idx = ptr_q - CW'(1);
  assign rd_gray = rdata_q[STOP_W-1:COLOR_W];
  assign rd_col  = rdata_q[COLOR_W-1:0];

  assign hit = cmd_i.scan && dv_q && have_lo_q &&
               (value_q >= lo_gray_q) && (value_q <= rd_gray);

  assign status_o.in_lookup = (command_i == CMD_LOOKUP);
  assign status_o.few       = stop_count_q < COUNT_W'(2);
  assign status_o.hit       = hit;
  assign status_o.equal     = (rd_gray == lo_gray_q);
  assign status_o.miss      = cmd_i.scan && dv_q && !hit && (ptr_q == n_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      stop_mem_q[waddr] <= {stop_gray_i, stop_color_i};
    end
    if (rd_en) begin
      rdata_q <= stop_mem_q[ptr_q[AW-1:0]];
    end
  end

  // restoring division, first bit taken without a shift
  assign div_t  = cmd_i.div_first ? rem_q : {rem_q[WEIGHT_W-2:0], 1'b0};
  assign div_ge = div_t >= WEIGHT_W'(dsr_q);
  assign div_d  = div_ge ? (div_t - WEIGHT_W'(dsr_q)) : div_t;

  // blend of the lowest channel, colours shift down a channel per step
  assign w2  = WEIGHT_W'(1 << GRAY_W) - q_q;
  assign acc = 25'(lo_col_q[CHAN_W-1:0]) * 25'(q_q)
             + 25'(hi_col_q[CHAN_W-1:0]) * 25'(w2)
             + 25'(1 << (GRAY_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= STOP_COUNT_RESET;
      dv_q         <= 1'b0;
      have_lo_q    <= 1'b0;
      found_q      <= 1'b0;
      res_found_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stop_count_q <= cfg_data_i;
      end
      dv_q <= rd_en;
      if (cmd_i.start) begin
        have_lo_q   <= 1'b0;
        res_found_q <= 1'b0;
      end else if (cmd_i.scan && dv_q && !hit) begin
        have_lo_q <= 1'b1;
      end
      if (hit) begin
        res_found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        found_q <= res_found_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      value_q   <= gray_value_i;
      n_q       <= n_ext[CW-1:0];
      ptr_q     <= '0;
      res_seg_q <= '0;
      res_col_q <= '0;
    end else begin
      if (rd_en) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (hit) begin
        res_seg_q <= lo_idx_q;
        hi_col_q  <= rd_col;
        rem_q     <= WEIGHT_W'(rd_gray - value_q);
        dsr_q     <= rd_gray - lo_gray_q;
      end else if (cmd_i.scan && dv_q) begin
        lo_gray_q <= rd_gray;
        lo_col_q  <= rd_col;
        lo_idx_q  <= arr_idx[AW-1:0];
      end
      if (cmd_i.take_lo) begin
        res_col_q <= lo_col_q;
      end
      if (cmd_i.div_step) begin
        rem_q <= div_d;
        q_q   <= {q_q[WEIGHT_W-2:0], div_ge};
      end
      if (cmd_i.blend_step) begin
        res_col_q <= {acc[23:16], res_col_q[COLOR_W-1:CHAN_W]};
        lo_col_q  <= {CHAN_W'(0), lo_col_q[COLOR_W-1:CHAN_W]};
        hi_col_q  <= {CHAN_W'(0), hi_col_q[COLOR_W-1:CHAN_W]};
      end
    end
    if (cmd_i.load_out) begin
      segment_q <= seg_ext[INDEX_W-1:0];
      color_q   <= res_col_q;
    end
  end

  // segment index is reported modulo eight
  assign seg_ext = 8'(res_seg_q);

  assign found_o   = found_q;
  assign segment_o = segment_q;
  assign color_o   = color_q;

endmodule

// ===== design/palette_gradient_interpolator.sv =====
// ----------------------------------------------------------------------------
// palette_gradient_interpolator
// Piecewise linear colour gradient lookup over up to MAX_STOPS palette stops.
// ----------------------------------------------------------------------------
// A write beat stores one stop. A lookup beat scans the stops through the one
// read port of the stop memory, one stop a cycle, then forms the lower weight
// in a restoring divider, one quotient bit a cycle, and blends one channel a
// cycle. A segment with equal bounds skips the divider and the blend, a miss
// scans all n stops, n the stop count saturated to MAX_STOPS, and fewer than
// two stops skip the scan; a result still waiting in the output register
// holds the lookup behind it. One item is worked on at a time; the result sits
// in an output register, so the next beat is taken while it waits.
// stop_count is written through cfg_we_i / cfg_data_i; the user must write it
// only while idle, as the block itself does not enforce it.
module palette_gradient_interpolator #(
  parameter int MAX_STOPS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pgi_in_if.sink                      in_if,
  pgi_out_if.source                   out_if,
  input  logic                        cfg_we_i,
  input  logic [pgi_pkg::COUNT_W-1:0] cfg_data_i
);
  import pgi_pkg::*;

  pgi_cmd_t           cmd;
  pgi_status_t        status;
  logic               in_ready;
  logic               out_valid;
  logic [COLOR_W-1:0] stop_color;
  logic [COLOR_W-1:0] color;

  assign stop_color = {in_if.stop_alpha, in_if.stop_blue, in_if.stop_green, in_if.stop_red};

  pgi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pgi_datapath #(
    .MAX_STOPS (MAX_STOPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (in_if.command),
    .stop_index_i (in_if.stop_index),
    .stop_gray_i  (in_if.stop_gray),
    .stop_color_i (stop_color),
    .gray_value_i (in_if.gray_value),
    .found_o      (out_if.found),
    .segment_o    (out_if.segment),
    .color_o      (color)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.red   = color[CHAN_W-1:0];
  assign out_if.green = color[2*CHAN_W-1:CHAN_W];
  assign out_if.blue  = color[3*CHAN_W-1:2*CHAN_W];
  assign out_if.alpha = color[4*CHAN_W-1:3*CHAN_W];

endmodule

// ===== design/pgi_checker.sv =====
// ----------------------------------------------------------------------------
// pgi_checker
// Port level checks of the palette gradient interpolator, bound to the top.
// ----------------------------------------------------------------------------
module pgi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_command_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       found_i,
  input logic [2:0] segment_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i
);
  import pgi_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a miss carries an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> segment_i == 3'd0 && red_i == 8'd0 &&
      green_i == 8'd0 && blue_i == 8'd0 && alpha_i == 8'd0)
    else $error("miss with non-zero payload");

  // a stop write never produces a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_command_i == CMD_WRITE && !out_valid_i |=> !out_valid_i)
    else $error("result beat after a stop write");

  // once a lookup is taken, the input drops ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_command_i == CMD_LOOKUP |=> !in_ready_i)
    else $error("input taken during a lookup");

endmodule

bind palette_gradient_interpolator pgi_checker u_pgi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .in_command_i (in_if.command),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .found_i      (out_if.found),
  .segment_i    (out_if.segment),
  .red_i        (out_if.red),
  .green_i      (out_if.green),
  .blue_i       (out_if.blue),
  .alpha_i      (out_if.alpha)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives palette writes and gray lookups into the gradient interpolator and
// checks every returned colour against an in-bench prediction of the blend.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_STOPS      = 8;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 120;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 64;
  localparam int LIMIT_CYCLES   = 600000;

  localparam logic [3:0] PHASE_COUNTS [NUM_PHASES] =
    '{4'd8, 4'd15, 4'd3, 4'd8, 4'd0, 4'd6, 4'd1, 4'd9, 4'd2, 4'd8, 4'd4, 4'd7};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic        command;
    logic [2:0]  stop_index;
    logic [15:0] stop_gray;
    logic [7:0]  stop_red;
    logic [7:0]  stop_green;
    logic [7:0]  stop_blue;
    logic [7:0]  stop_alpha;
    logic [15:0] gray_value;
  } palette_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] segment;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } colour_result_t;

  class gradient_scoreboard;
    logic [15:0]    level [MAX_STOPS];
    logic [7:0]     chan [MAX_STOPS][4];
    logic [3:0]     stop_count;
    colour_result_t pending_colours [$];
    int             errors;

    function new();
      foreach (level[i]) begin
        level[i] = '0;
        for (int c = 0; c < 4; c++) chan[i][c] = '0;
      end
      stop_count = pgi_pkg::STOP_COUNT_RESET;
      errors = 0;
    endfunction

    function void set_count(logic [3:0] value);
      stop_count = value;
    endfunction

    function int pending();
      return pending_colours.size();
    endfunction

    // first segment holding the gray value, blended by its position inside
    function colour_result_t gradient_colour(logic [15:0] v);
      colour_result_t    res;
      int                n, k, seg;
      longint unsigned   lo, hi, span, w_lo, w_hi, acc;
      logic [7:0]        mix [4];
      res = '0;
      seg = -1;
      n = (stop_count > MAX_STOPS) ? MAX_STOPS : int'(stop_count);
      for (k = 0; k + 1 < n; k++)
        if (seg < 0 && v >= level[k] && v <= level[k+1]) seg = k;
      if (seg < 0) return res;
      lo = level[seg];
      hi = level[seg+1];
      span = hi - lo;
      for (k = 0; k < 4; k++) begin
        if (span == 0) begin
          mix[k] = chan[seg][k];
        end else begin
          w_lo = ((hi - longint'(v)) << 16) / span;
          if (w_lo > 65536) w_lo = 65536;
          w_hi = 65536 - w_lo;
          acc = (chan[seg][k] * w_lo + chan[seg+1][k] * w_hi + 32768) >> 16;
          mix[k] = (acc > 255) ? 8'd255 : acc[7:0];
        end
      end
      res.found   = 1'b1;
      res.segment = 3'(seg);
      res.red     = mix[0];
      res.green   = mix[1];
      res.blue    = mix[2];
      res.alpha   = mix[3];
      return res;
    endfunction

    function void note_input(palette_item_t it);
      if (it.command == pgi_pkg::CMD_WRITE) begin
        level[it.stop_index]   = it.stop_gray;
        chan[it.stop_index][0] = it.stop_red;
        chan[it.stop_index][1] = it.stop_green;
        chan[it.stop_index][2] = it.stop_blue;
        chan[it.stop_index][3] = it.stop_alpha;
      end else begin
        pending_colours.push_back(gradient_colour(it.gray_value));
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(colour_result_t got);
      colour_result_t want;
      if (pending_colours.size() == 0) begin
        $error("result beat with no lookup outstanding");
        errors++;
        return;
      end
      want = pending_colours.pop_front();
      compare_field("found", 8'(want.found), 8'(got.found));
      compare_field("segment", 8'(want.segment), 8'(got.segment));
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_data;
  int         cycle_count = 0;
  int         sent_items = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_req = 0;

  gradient_scoreboard sb = new();

  pgi_in_if  pal_in ();
  pgi_out_if pal_out ();

  palette_gradient_interpolator #(.MAX_STOPS(MAX_STOPS)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (pal_in),
    .out_if     (pal_out),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    colour_result_t got;
    int             hold_seen;
    int             hold_left;
    hold_seen = 0;
    hold_left = 0;
    pal_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pal_out.valid === 1'b1 && pal_out.ready === 1'b1) begin
        got.found   = pal_out.found;
        got.segment = pal_out.segment;
        got.red     = pal_out.red;
        got.green   = pal_out.green;
        got.blue    = pal_out.blue;
        got.alpha   = pal_out.alpha;
        sb.check_result(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pal_out.ready <= 1'b0;
      end else begin
        pal_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send(palette_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      pal_in.valid <= 1'b0;
      @(posedge clk);
    end
    pal_in.valid      <= 1'b1;
    pal_in.command    <= it.command;
    pal_in.stop_index <= it.stop_index;
    pal_in.stop_gray  <= it.stop_gray;
    pal_in.stop_red   <= it.stop_red;
    pal_in.stop_green <= it.stop_green;
    pal_in.stop_blue  <= it.stop_blue;
    pal_in.stop_alpha <= it.stop_alpha;
    pal_in.gray_value <= it.gray_value;
    do @(posedge clk); while (pal_in.ready !== 1'b1);
    sb.note_input(it);
    sent_items++;
  endtask

  // gray_value on a write beat is ignored, so it carries noise
  task automatic write_stop(logic [2:0] idx, logic [15:0] lvl, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b, logic [7:0] a);
    palette_item_t it;
    it = '{pgi_pkg::CMD_WRITE, idx, lvl, r, g, b, a, 16'($urandom)};
    send(it);
  endtask

  // stop fields on a lookup beat are ignored, so they carry noise
  task automatic lookup(logic [15:0] v);
    palette_item_t it;
    it = '{pgi_pkg::CMD_LOOKUP, 3'($urandom), 16'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom), v};
    send(it);
  endtask

  task automatic set_stop_count(logic [3:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(value);
  endtask

  task automatic settle();
    pal_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a full ascending palette, some segments flat, written in rotated order
  task automatic load_palette();
    logic [15:0] lvl [MAX_STOPS];
    int          g, rot, spread, idx;
    rot = $urandom_range(MAX_STOPS - 1);
    spread = $urandom_range(1, 3) * 3000;
    g = ($urandom_range(3) == 0) ? 0 : $urandom_range(8000);
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (i > 0 && $urandom_range(99) >= 15) g += $urandom_range(spread);
      if (g > 65535) g = 65535;
      lvl[i] = 16'(g);
    end
    if ($urandom_range(3) == 0) lvl[MAX_STOPS-1] = 16'hFFFF;
    for (int i = 0; i < MAX_STOPS; i++) begin
      idx = (i + rot) % MAX_STOPS;
      write_stop(3'(idx), lvl[idx], 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end
  endtask

  // gray values cluster on and around the stop levels to hit the bounds
  function automatic logic [15:0] pick_gray();
    int sel, k;
    sel = $urandom_range(99);
    k = $urandom_range(MAX_STOPS - 1);
    if (sel < 40) return 16'($urandom);
    if (sel < 70) return sb.level[k];
    if (sel < 90) return sel[0] ? sb.level[k] + 16'd1 : sb.level[k] - 16'd1;
    return sel[1] ? 16'hFFFF : 16'h0000;
  endfunction

  initial begin : stimulus
    idle_mode_e mode;
    int         first, roll;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    pal_in.valid      <= 1'b0;
    pal_in.command    <= pgi_pkg::CMD_WRITE;
    pal_in.stop_index <= '0;
    pal_in.stop_gray  <= '0;
    pal_in.stop_red   <= '0;
    pal_in.stop_green <= '0;
    pal_in.stop_blue  <= '0;
    pal_in.stop_alpha <= '0;
    pal_in.gray_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fixed palette: flat first segment, channel extremes, top stop at full scale
    write_stop(3'd0, 16'h2000, 8'd255, 8'd0, 8'd128, 8'd255);
    write_stop(3'd1, 16'h2000, 8'd0, 8'd255, 8'd1, 8'd0);
    write_stop(3'd2, 16'h5000, 8'd10, 8'd20, 8'd30, 8'd40);
    write_stop(3'd3, 16'h9000, 8'd255, 8'd255, 8'd255, 8'd255);
    write_stop(3'd4, 16'hA000, 8'd0, 8'd0, 8'd0, 8'd0);
    write_stop(3'd5, 16'hC000, 8'd200, 8'd100, 8'd50, 8'd25);
    write_stop(3'd6, 16'hF000, 8'd7, 8'd77, 8'd177, 8'd254);
    write_stop(3'd7, 16'hFFFF, 8'd1, 8'd2, 8'd3, 8'd4);
    // reset count of two: only the flat first segment is live
    lookup(16'h2000);
    lookup(16'h0000);
    lookup(16'h3000);
    settle();
    set_stop_count(4'd8);
    lookup(16'h2000);
    lookup(16'h3000);
    lookup(16'h5000);
    lookup(16'h8FFF);
    lookup(16'h9000);
    lookup(16'hA000);
    lookup(16'hB000);
    lookup(16'hF000);
    lookup(16'hFFFF);
    lookup(16'h1FFF);
    settle();
    set_stop_count(4'd1);
    lookup(16'h5000);
    settle();
    set_stop_count(4'd0);
    lookup(16'h5000);
    settle();
    // count above the store size saturates
    set_stop_count(4'd15);
    lookup(16'hFFFF);
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_stop_count(PHASE_COUNTS[phase]);
      mode = idle_mode_e'(phase % 4);
      case (mode)
        IDLE_NONE: begin
          sender_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        IDLE_SENDER: begin
          sender_idle_pct = 55;
          recv_stall_pct <= 0;
        end
        IDLE_RECEIVER: begin
          sender_idle_pct = 0;
          recv_stall_pct <= 55;
        end
        default: begin
          sender_idle_pct = 7;
          recv_stall_pct <= 7;
        end
      endcase
      if (phase == PRESSURE_PHASE) hold_req <= hold_req + 1;
      first = sent_items;
      load_palette();
      while (sent_items - first < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          load_palette();
        end else if (roll < 12) begin
          // stray write that may break the ordering of the palette
          write_stop(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
        end else begin
          lookup(pick_gray());
        end
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== palette_gradient_interpolator.f =====
design/pgi_pkg.sv
design/pgi_if.sv
design/pgi_ctrl.sv
design/pgi_datapath.sv
design/palette_gradient_interpolator.sv
design/pgi_checker.sv
bench/testbench.sv
